// ----- rtl/psl_pkg.sv -----
// Package for the Phong specular lobe unit: payload types, register codes, log/exp tables.
package psl_pkg;

    localparam int LOG_TABLE_BITS = 8;
    localparam int LOG_ENTRIES    = 1 << LOG_TABLE_BITS;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [15:0] incident_x;
        logic signed [15:0] incident_y;
        logic signed [15:0] incident_z;
        logic signed [15:0] view_x;
        logic signed [15:0] view_y;
        logic signed [15:0] view_z;
    } psl_in_t;

    typedef struct packed {
        logic [15:0] out_red;
        logic [15:0] out_green;
        logic [15:0] out_blue;
    } psl_out_t;

    // Classification of the cosine, decided once c is known
    typedef struct packed {
        logic nolobe;   // c <= 0: black
        logic unity;    // exponent zero or c saturated: power is 1.0
        logic tiny;     // c16 is zero: power is 0
    } psl_cls_t;

    typedef enum logic [2:0] {
        REG_GAIN        = 3'd0,
        REG_COLOR_RED   = 3'd1,
        REG_COLOR_GREEN = 3'd2,
        REG_COLOR_BLUE  = 3'd3,
        REG_EXPONENT    = 3'd4
    } psl_reg_t;

    typedef logic [LOG_ENTRIES-1:0][15:0] log_rom_t;
    typedef logic [LOG_ENTRIES-1:0][16:0] exp_rom_t;

    // Fractional bits of log2(y/2^16) for y in [2^16, 2^17), by repeated squaring
    function automatic logic [15:0] log16(input logic [63:0] y);
        logic [63:0] x;
        logic [15:0] res;
        x   = y << 14;
        res = '0;
        for (int i = 0; i < 16; i++)
        begin
            x   = (x * x) >> 30;
            res = {res[14:0], 1'b0};
            if (x >= (64'd2 << 30))
            begin
                res[0] = 1'b1;
                x      = x >> 1;
            end
        end
        return res;
    endfunction

    function automatic log_rom_t build_log_rom();
        log_rom_t tab;
        for (int i = 0; i < LOG_ENTRIES; i++)
            tab[i] = log16(64'd65536 + (64'(i) << (16 - LOG_TABLE_BITS)));
        return tab;
    endfunction

    function automatic exp_rom_t build_exp_rom();
        exp_rom_t    tab;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] target;
        for (int i = 0; i < LOG_ENTRIES; i++)
        begin
            target = 64'(i) << (16 - LOG_TABLE_BITS);
            lo     = 64'd65536;
            hi     = 64'd131071;
            for (int s = 0; s < 18; s++)
            begin
                if (lo < hi)
                begin
                    mid = (lo + hi) >> 1;
                    if (64'(log16(mid)) >= target)
                        hi = mid;
                    else
                        lo = mid + 64'd1;
                end
            end
            tab[i] = lo[16:0];
        end
        return tab;
    endfunction

    localparam log_rom_t LOG_ROM = build_log_rom();
    localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

// ----- rtl/psl_reflect.sv -----
// Reflection and cosine pipeline: six stages from the vectors to c = r.wo.
module psl_reflect (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  psl_pkg::psl_in_t  in_data,
    input  logic [15:0]       exponent,
    output logic              out_valid,
    output logic [15:0]       c16,
    output psl_pkg::psl_cls_t cls
);
    import psl_pkg::*;

    logic [5:0] vld_reg;

    // stage 1
    logic signed [15:0] n1_reg [3];
    logic signed [15:0] wi1_reg [3];
    logic signed [15:0] wo1_reg [3];
    logic signed [31:0] p1_reg [3];
    // stage 2
    logic signed [15:0] n2_reg [3];
    logic signed [15:0] wi2_reg [3];
    logic signed [15:0] wo2_reg [3];
    logic signed [33:0] d2_reg;
    // stage 3
    logic signed [15:0] wi3_reg [3];
    logic signed [15:0] wo3_reg [3];
    logic signed [36:0] q3_reg [3];
    // stage 4
    logic signed [15:0] wo4_reg [3];
    logic signed [37:0] r4_reg [3];
    // stage 5
    logic signed [53:0] m5_reg [3];
    // stage 6
    logic [15:0]        c16_reg;
    psl_cls_t           cls_reg;

    logic signed [15:0] n_in [3];
    logic signed [15:0] wi_in [3];
    logic signed [15:0] wo_in [3];
    logic signed [49:0] q_full [3];
    logic signed [55:0] c_sum;

    assign n_in[0]  = in_data.normal_x;
    assign n_in[1]  = in_data.normal_y;
    assign n_in[2]  = in_data.normal_z;
    assign wi_in[0] = in_data.incident_x;
    assign wi_in[1] = in_data.incident_y;
    assign wi_in[2] = in_data.incident_z;
    assign wo_in[0] = in_data.view_x;
    assign wo_in[1] = in_data.view_y;
    assign wo_in[2] = in_data.view_z;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            q_full[k] = 50'(n2_reg[k]) * 50'(d2_reg);
        c_sum = 56'(m5_reg[0]) + 56'(m5_reg[1]) + 56'(m5_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[4:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                n1_reg[k]  <= n_in[k];
                wi1_reg[k] <= wi_in[k];
                wo1_reg[k] <= wo_in[k];
                p1_reg[k]  <= n_in[k] * wi_in[k];
                n2_reg[k]  <= n1_reg[k];
                wi2_reg[k] <= wi1_reg[k];
                wo2_reg[k] <= wo1_reg[k];
                wi3_reg[k] <= wi2_reg[k];
                wo3_reg[k] <= wo2_reg[k];
                // 2*n*d floored by 2^14 equals n*d floored by 2^13
                q3_reg[k]  <= 37'(q_full[k] >>> 13);
                wo4_reg[k] <= wo3_reg[k];
                r4_reg[k]  <= 38'(q3_reg[k]) - (38'(wi3_reg[k]) <<< 14);
                m5_reg[k]  <= 54'(r4_reg[k]) * 54'(wo4_reg[k]);
            end
            d2_reg         <= 34'(p1_reg[0]) + 34'(p1_reg[1]) + 34'(p1_reg[2]);
            c16_reg        <= c_sum[41:26];
            cls_reg.nolobe <= (c_sum <= 56'sd0);
            cls_reg.unity  <= (exponent == 16'd0) || (c_sum >= (56'sd1 <<< 42));
            cls_reg.tiny   <= (c_sum[41:26] == 16'd0);
        end
    end

    assign out_valid = vld_reg[5];
    assign c16       = c16_reg;
    assign cls       = cls_reg;

endmodule

// ----- rtl/psl_power.sv -----
// Power pipeline: log2 lookup, scale by exponent, exp2 lookup, three stages.
module psl_power (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [15:0]       c16,
    input  psl_pkg::psl_cls_t cls,
    input  logic [15:0]       exponent,
    output logic              out_valid,
    output logic [16:0]       p
);
    import psl_pkg::*;

    logic [2:0]         vld_reg;
    logic signed [21:0] lg_reg;
    psl_cls_t           cls7_reg;
    logic signed [38:0] prod_reg;
    psl_cls_t           cls8_reg;
    logic [16:0]        p_reg;

    logic [3:0]                pos;
    logic [15:0]               norm;
    logic [LOG_TABLE_BITS-1:0] log_idx;
    logic [5:0]                lg_int;
    logic signed [30:0]        t;
    logic signed [14:0]        kk;
    logic [14:0]               negk;
    logic [LOG_TABLE_BITS-1:0] exp_idx;
    logic [16:0]               p_next;

    always_comb
    begin
        pos = '0;
        for (int i = 1; i < 16; i++)
            if (c16[i])
                pos = 4'(i);
        norm    = c16 << (4'd15 - pos);
        log_idx = norm[14 -: LOG_TABLE_BITS];
        lg_int  = {2'b00, pos} - 6'd16;

        t       = 31'(prod_reg >>> 8);
        kk      = t[30:16];
        negk    = 15'(-kk);
        exp_idx = t[15 -: LOG_TABLE_BITS];
        if (cls8_reg.nolobe)
            p_next = '0;
        else if (cls8_reg.unity)
            p_next = 17'd65536;
        else if (cls8_reg.tiny || (negk >= 15'd32))
            p_next = '0;
        else
            p_next = EXP_ROM[exp_idx] >> negk[4:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lg_reg   <= {lg_int, LOG_ROM[log_idx]};
            cls7_reg <= cls;
            prod_reg <= 39'(lg_reg) * $signed({23'd0, exponent});
            cls8_reg <= cls7_reg;
            p_reg    <= p_next;
        end
    end

    assign out_valid = vld_reg[2];
    assign p         = p_reg;

endmodule

// ----- rtl/phong_specular_lobe_unit.sv -----
// Top level of the Phong specular lobe unit: config registers, pipeline, color scaling.
//
// Usage:
// - Input channel in_valid/in_ready/in_data carries one beat per shading sample:
//   normal, incident and outgoing directions, each signed Q1.14.
// - Output channel out_valid/out_ready/out_data returns one beat per input beat:
//   red, green and blue specular intensity, unsigned Q1.15, saturating.
// - Config port cfg_write/cfg_index/cfg_data writes gain, the three colors and
//   the Q8.8 exponent; unknown indices are dropped. Write only while idle.
// - From input beat to output beat, six stages form the
//   reflected cosine, three stages form the power through the log2/exp2
//   tables, and two stages scale by gain*color and saturate.
// - Throughput is one beat per cycle while the pipeline is not held; every stage is a register with a valid bit.
// - When the receiver stalls with a beat in the last stage, the whole pipeline holds;
//   in_ready drops only while that beat is not taken, so nothing is lost.
// - Reset clears all valid bits and all config registers to zero.
module phong_specular_lobe_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  psl_pkg::psl_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output psl_pkg::psl_out_t out_data,
    input  logic              cfg_write,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data
);
    import psl_pkg::*;

    logic [15:0] gain_reg;
    logic [15:0] color_reg [3];
    logic [15:0] exponent_reg;
    // gain*color, refreshed every cycle from the config registers
    logic [31:0] gc_reg [3];

    logic        en;
    logic        refl_valid;
    logic [15:0] refl_c16;
    psl_cls_t    refl_cls;
    logic        pow_valid;
    logic [16:0] pow_p;

    logic [1:0]  vld_reg;
    logic [48:0] sc_reg [3];
    logic [15:0] out_reg [3];
    logic [17:0] sc_top [3];

    // advance the pipeline unless the last stage holds an untaken beat
    assign en       = !vld_reg[1] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg     <= '0;
            color_reg[0] <= '0;
            color_reg[1] <= '0;
            color_reg[2] <= '0;
            exponent_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_GAIN:        gain_reg     <= cfg_data;
                REG_COLOR_RED:   color_reg[0] <= cfg_data;
                REG_COLOR_GREEN: color_reg[1] <= cfg_data;
                REG_COLOR_BLUE:  color_reg[2] <= cfg_data;
                REG_EXPONENT:    exponent_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    psl_reflect u_reflect (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .exponent  (exponent_reg),
        .out_valid (refl_valid),
        .c16       (refl_c16),
        .cls       (refl_cls)
    );

    psl_power u_power (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (refl_valid),
        .c16       (refl_c16),
        .cls       (refl_cls),
        .exponent  (exponent_reg),
        .out_valid (pow_valid),
        .p         (pow_p)
    );

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            sc_top[k] = sc_reg[k][48:31];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[0], pow_valid};
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
            gc_reg[k] <= 32'(gain_reg) * 32'(color_reg[k]);
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sc_reg[k]  <= 49'(gc_reg[k]) * 49'(pow_p);
                // saturate at the top of Q1.15
                out_reg[k] <= (sc_top[k] > 18'd65535) ? 16'hFFFF : sc_top[k][15:0];
            end
        end
    end

    assign out_valid          = vld_reg[1];
    assign out_data.out_red   = out_reg[0];
    assign out_data.out_green = out_reg[1];
    assign out_data.out_blue  = out_reg[2];

endmodule

// ----- tb/tb_top.sv -----
// Testbench for the Phong specular lobe unit: random and directed samples checked by a scoreboard.
`timescale 1ns / 1ps

class lobe_scoreboard;
    psl_pkg::psl_out_t pending[$];
    int                errors;
    logic [15:0]       gain;
    logic [15:0]       color_red;
    logic [15:0]       color_green;
    logic [15:0]       color_blue;
    logic [15:0]       exponent;

    function new();
        errors = 0;
        gain = '0; color_red = '0; color_green = '0; color_blue = '0; exponent = '0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
        case (idx)
            psl_pkg::REG_GAIN:        gain = val;
            psl_pkg::REG_COLOR_RED:   color_red = val;
            psl_pkg::REG_COLOR_GREEN: color_green = val;
            psl_pkg::REG_COLOR_BLUE:  color_blue = val;
            psl_pkg::REG_EXPONENT:    exponent = val;
            default: ;
        endcase
    endfunction

    // Fractional log2 bits by repeated truncating squaring
    function automatic longint unsigned log_frac(longint unsigned y);
        longint unsigned x;
        longint unsigned res;
        x = y << 14;
        res = 0;
        for (int i = 0; i < 16; i++)
        begin
            x = (x * x) >> 30;
            res = res << 1;
            if (x >= (64'd2 << 30))
            begin
                res = res | 1;
                x = x >> 1;
            end
        end
        return res;
    endfunction

    function automatic longint unsigned exp_entry(longint unsigned idx);
        longint unsigned target;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        target = idx << (16 - psl_pkg::LOG_TABLE_BITS);
        lo = 65536;
        hi = 131071;
        while (lo < hi)
        begin
            mid = (lo + hi) >> 1;
            if (log_frac(mid) >= target) hi = mid;
            else lo = mid + 1;
        end
        return lo;
    endfunction

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [15:0] scale(logic [15:0] col, longint unsigned p);
        longint unsigned v;
        v = (longint'(gain) * longint'(col) * p) >> 31;
        return (v > 65535) ? 16'hFFFF : v[15:0];
    endfunction

    // Work out the color beat this sample must produce
    function void note_sample(psl_pkg::psl_in_t s);
        longint n[3];
        longint wi[3];
        longint wo[3];
        longint d;
        longint c;
        longint r;
        longint lg;
        longint t;
        longint kk;
        longint f;
        longint unsigned p;
        longint unsigned c16;
        longint unsigned m;
        int pos;
        psl_pkg::psl_out_t o;
        n[0] = s.normal_x;   n[1] = s.normal_y;   n[2] = s.normal_z;
        wi[0] = s.incident_x; wi[1] = s.incident_y; wi[2] = s.incident_z;
        wo[0] = s.view_x;    wo[1] = s.view_y;    wo[2] = s.view_z;
        d = 0;
        c = 0;
        for (int k = 0; k < 3; k++) d += n[k] * wi[k];
        for (int k = 0; k < 3; k++)
        begin
            r = floor_shift(2 * n[k] * d, 14) - wi[k] * 16384;
            c += r * wo[k];
        end
        if (c <= 0)
            p = 0;
        else if (exponent == 0 || c >= (64'sd1 <<< 42))
            p = 65536;
        else
        begin
            c16 = longint'(c) >> 26;
            if (c16 == 0)
                p = 0;
            else
            begin
                pos = 15;
                while (pos > 0 && !c16[pos]) pos--;
                m = (c16 << (15 - pos)) & 16'h7FFF;
                lg = longint'(pos - 16) * 65536 + longint'(log_frac(65536 +
                     ((m >> (15 - psl_pkg::LOG_TABLE_BITS)) << (16 - psl_pkg::LOG_TABLE_BITS))));
                t = floor_shift(lg * longint'(exponent), 8);
                kk = floor_shift(t, 16);
                f = t - kk * 65536;
                if (-kk >= 32) p = 0;
                else p = exp_entry(f >> (16 - psl_pkg::LOG_TABLE_BITS)) >> (-kk);
            end
        end
        o.out_red = scale(color_red, p);
        o.out_green = scale(color_green, p);
        o.out_blue = scale(color_blue, p);
        pending.push_back(o);
    endfunction

    function void check_beat(psl_pkg::psl_out_t got);
        psl_pkg::psl_out_t want;
        if (pending.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected beat %h", $time, got);
            return;
        end
        want = pending.pop_front();
        if (got.out_red !== want.out_red)
        begin
            errors++;
            $display("%0t: red exp %h got %h", $time, want.out_red, got.out_red);
        end
        if (got.out_green !== want.out_green)
        begin
            errors++;
            $display("%0t: green exp %h got %h", $time, want.out_green, got.out_green);
        end
        if (got.out_blue !== want.out_blue)
        begin
            errors++;
            $display("%0t: blue exp %h got %h", $time, want.out_blue, got.out_blue);
        end
    endfunction
endclass

module tb_top;
    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    psl_pkg::psl_in_t  in_data;
    logic              out_valid;
    logic              out_ready;
    psl_pkg::psl_out_t out_data;
    logic              cfg_write;
    logic [2:0]        cfg_index;
    logic [15:0]       cfg_data;

    lobe_scoreboard sb;
    int send_idle_pct;   // chance per cycle that the sender holds off
    int recv_stall_pct;  // chance per cycle that the receiver stalls

    phong_specular_lobe_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Receiver: randomize ready each cycle, check every accepted beat
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_beat(out_data);
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Write one register, then leave the port idle before returning
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        sb.write_reg(idx, val);
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid, wait for the pipe to drain, then wait a little longer on an idle pipe
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // Present one beat; idle gaps are inserted before it, never after valid rises
    task automatic send_beat(input psl_pkg::psl_in_t s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_sample(s);
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(5))
            0: return 16'($urandom_range(32768) - 16384);
            1: return 16'h4000;
            2: return 16'hC000;
            3: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Raw bits, edge components, or unit-ish vectors with wo near mirror to exercise the lobe
    function automatic psl_pkg::psl_in_t rand_sample();
        psl_pkg::psl_in_t s;
        int j;
        s = '0;
        if ($urandom_range(99) < 25)
            s = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
        else if ($urandom_range(99) < 30)
        begin
            s.normal_x = rand_comp(); s.normal_y = rand_comp(); s.normal_z = rand_comp();
            s.incident_x = rand_comp(); s.incident_y = rand_comp();
            s.incident_z = rand_comp(); s.view_x = rand_comp(); s.view_y = rand_comp();
            s.view_z = rand_comp();
        end
        else
        begin
            j = $urandom_range(2000);
            s.normal_z = 16'sd16384;
            s.normal_x = 16'($urandom_range(2 * j) - j);
            s.incident_x = 16'($urandom_range(16000) - 8000);
            s.incident_z = 16'($urandom_range(16384, 8000));
            s.view_x = -s.incident_x + 16'($urandom_range(2 * j) - j);
            s.view_z = s.incident_z - 16'($urandom_range(j));
            s.view_y = 16'($urandom_range(2 * j) - j);
        end
        return s;
    endfunction

    task automatic random_setting();
        write_reg(psl_pkg::REG_GAIN, ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom));
        write_reg(psl_pkg::REG_COLOR_RED, 16'($urandom));
        write_reg(psl_pkg::REG_COLOR_GREEN, ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom));
        write_reg(psl_pkg::REG_COLOR_BLUE, ($urandom_range(3) == 0) ? 16'h0000 : 16'($urandom));
        case ($urandom_range(3))
            0: write_reg(psl_pkg::REG_EXPONENT, 16'($urandom_range(4095)));
            1: write_reg(psl_pkg::REG_EXPONENT, 16'($urandom_range(16383)));
            2: write_reg(psl_pkg::REG_EXPONENT, 16'hFFFF);
            default: write_reg(psl_pkg::REG_EXPONENT, 16'($urandom));
        endcase
    endtask

    initial
    begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        psl_pkg::psl_in_t s;
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: mid setting, then extremes of the fields
        write_reg(psl_pkg::REG_GAIN, 16'h8000);
        write_reg(psl_pkg::REG_COLOR_RED, 16'hFFFF);
        write_reg(psl_pkg::REG_COLOR_GREEN, 16'h4000);
        write_reg(psl_pkg::REG_COLOR_BLUE, 16'h0000);
        write_reg(psl_pkg::REG_EXPONENT, 16'h0A00);
        write_reg(3'd7, 16'h1234);  // unknown index, dropped
        s = '0;
        s.normal_z = 16'sd16384; s.incident_z = 16'sd16384; s.view_z = 16'sd16384;
        send_beat(s);                        // saturated cosine
        s.view_z = -16'sd16384;
        send_beat(s);                        // no lobe
        s.view_z = 16'sd0; s.view_x = 16'sd1;
        send_beat(s);                        // zero cosine, no lobe
        s.view_x = 16'sd0; s.view_z = 16'sd8192;
        send_beat(s);                        // half cosine
        s.view_z = 16'sd200;
        send_beat(s);                        // small cosine
        s = {9{16'h8000}};
        send_beat(s);
        s = {9{16'h7FFF}};
        send_beat(s);                        // overflowing cosine
        s = {9{16'hFFFF}};
        send_beat(s);
        drain();
        write_reg(psl_pkg::REG_EXPONENT, 16'h0000);
        write_reg(psl_pkg::REG_GAIN, 16'hFFFF);
        s = '0;
        s.normal_z = 16'sd16384; s.incident_z = 16'sd16384; s.view_z = 16'sd1;
        send_beat(s);                        // exponent zero on very small cosine
        s.view_z = 16'sd8192;
        send_beat(s);                        // exponent zero, overflow on red
        drain();
        write_reg(psl_pkg::REG_EXPONENT, 16'hFFFF);
        s.view_z = 16'sd16000;
        send_beat(s);
        s.view_z = 16'sd4096;
        send_beat(s);                        // deep underflow
        drain();

        // Random phases with different idling mixes
        for (int ph = 0; ph < 8; ph++)
        begin
            random_setting();
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            for (int i = 0; i < 192; i++)
            begin
                send_beat(rand_sample());
                if (i == 96 && ph == 3)
                    drain();  // hold until drained
            end
            drain();
        end

        recv_stall_pct = 0;
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
